// ===== hdl/tsep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsep_pkg
// Shared types and constants of the tagged string escape parser.
// ----------------------------------------------------------------------------
package tsep_pkg;

    // argument limit per tag, field_index stays within 5 bits
    localparam int MAX_ARGS     = 16;
    localparam int DEF_MAX_TAGS = 64;

    localparam int TAG_IDX_W   = 6;
    localparam int FIELD_IDX_W = 5;

    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;  // =
    localparam logic [7:0] CH_COMMA  = 8'h2C;  // ,
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CC_BS     = 8'h08;
    localparam logic [7:0] CC_FF     = 8'h0C;
    localparam logic [7:0] CC_LF     = 8'h0A;
    localparam logic [7:0] CC_CR     = 8'h0D;
    localparam logic [7:0] CC_TAB    = 8'h09;

    typedef enum logic [2:0] {
        KIND_CHAR    = 3'd0,
        KIND_TAG     = 3'd1,
        KIND_ARG     = 3'd2,
        KIND_DROPPED = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ESC_NORMAL = 4'b0001,
        ESC_BSL    = 4'b0010,
        ESC_HEX0   = 4'b0100,
        ESC_HEX1   = 4'b1000
    } esc_t;

    typedef struct packed {
        esc_t                   esc;
        logic [3:0]             nib;
        logic [FIELD_IDX_W-1:0] arg;
        logic                   disc;
        logic                   ok;
    } parse_state_t;

    typedef struct packed {
        kind_t                  kind;
        logic [7:0]             char_value;
        logic [TAG_IDX_W-1:0]   tag_index;
        logic [FIELD_IDX_W-1:0] field_index;
        logic                   hidden;
        logic                   all_ok;
        logic                   last;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/tagged_string_escape_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tagged_string_escape_parser
// Byte-serial parser for tagged display strings with backslash escapes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one request per cycle unless stalled,
//   carrying one raw byte or, with end_of_string high, the end of the string.
//   Output channel (out_valid / out_stall): one result per cycle unless
//   stalled; a request gives zero, one or two results, its final one has last set.
//   Results of a request are written into a four-entry result queue at the
//   accepting edge and offered from its head.
//   Throughput: one request per cycle while each gives at most one result
//   and out_stall is low; two results of one request are offered in turn.
//   The queue depth sets it: in_stall rises once three or more results wait.
//   A stalled receiver keeps the head result steady and fills the queue
//   until in_stall stops the sender; no result is lost or repeated.
//   Reset: the parser returns to normal mode, tag 0, field 0, all_ok set,
//   and the queue is emptied. An end_of_string request does the same to the
//   parser state after its results are queued.
// ----------------------------------------------------------------------------
module tagged_string_escape_parser
    import tsep_pkg::*;
#(
    parameter int MAX_TAGS = DEF_MAX_TAGS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             byte_in,
    input  wire logic                   end_of_string,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [2:0]                  kind,
    output logic [7:0]                  char_value,
    output logic [TAG_IDX_W-1:0]        tag_index,
    output logic [FIELD_IDX_W-1:0]      field_index,
    output logic                        hidden,
    output logic                        all_ok,
    output logic                        last
);

    localparam int TAG_W = $clog2(MAX_TAGS);

    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    logic [1:0]       res_cnt;
    result_t          res0;
    result_t          res1;

    result_t          queue_reg [4];
    logic [1:0]       wr_ptr_reg;
    logic [1:0]       rd_ptr_reg;
    logic [2:0]       count_reg;
    logic [2:0]       count_next;
    logic             in_take;
    logic             out_take;
    logic [1:0]       push;
    result_t          head;

    tsep_step #(
        .MAX_TAGS (MAX_TAGS),
        .TAG_W    (TAG_W)
    ) u_step (
        .byte_in       (byte_in),
        .end_of_string (end_of_string),
        .state_cur     (state_reg),
        .tag_cur       (tag_reg),
        .state_nxt     (state_next),
        .tag_nxt       (tag_next),
        .res_cnt       (res_cnt),
        .res0          (res0),
        .res1          (res1)
    );

    assign in_stall = (count_reg > 3'd2);
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign push     = in_take ? res_cnt : 2'd0;
    assign count_next = count_reg + {1'b0, push} - {2'd0, out_take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.esc  <= ESC_NORMAL;
            state_reg.nib  <= 4'd0;
            state_reg.arg  <= '0;
            state_reg.disc <= 1'b0;
            state_reg.ok   <= 1'b1;
            tag_reg        <= '0;
            wr_ptr_reg     <= 2'd0;
            rd_ptr_reg     <= 2'd0;
            count_reg      <= 3'd0;
        end
        else
        begin
            if (in_take)
            begin
                state_reg  <= state_next;
                tag_reg    <= tag_next;
                wr_ptr_reg <= wr_ptr_reg + push;
            end
            if (out_take)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    // result storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push != 2'd0)
            queue_reg[wr_ptr_reg] <= res0;
        if (push == 2'd2)
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
    end

    assign head        = queue_reg[rd_ptr_reg];
    assign out_valid   = (count_reg != 3'd0);
    assign kind        = head.kind;
    assign char_value  = head.char_value;
    assign tag_index   = head.tag_index;
    assign field_index = head.field_index;
    assign hidden      = head.hidden;
    assign all_ok      = head.all_ok;
    assign last        = head.last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue count out of range");

    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("second result of a request missing");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == KIND_END)) |-> last)
        else $error("end of string result without last");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && end_of_string)
        |=> (tag_reg == '0) && state_reg.ok && (state_reg.arg == '0))
        else $error("parser state not cleared after end of string");

endmodule
`default_nettype wire

// ===== hdl/tsep_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsep_step
// One parse step: decodes a request against the parser state and gives the
// next state and up to two results.
// ----------------------------------------------------------------------------
module tsep_step
    import tsep_pkg::*;
#(
    parameter int MAX_TAGS = DEF_MAX_TAGS,
    parameter int TAG_W    = $clog2(MAX_TAGS)
)
(
    input  wire logic [7:0]       byte_in,
    input  wire logic             end_of_string,
    input  wire parse_state_t     state_cur,
    input  wire logic [TAG_W-1:0] tag_cur,
    output parse_state_t          state_nxt,
    output logic [TAG_W-1:0]      tag_nxt,
    output logic [1:0]            res_cnt,
    output result_t               res0,
    output result_t               res1
);

    // {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b inside {[8'h30:8'h39]}) r = {1'b1, 4'(b - 8'h30)};
        else if (b inside {[8'h41:8'h46]}) r = {1'b1, 4'(b - 8'h37)};
        else if (b inside {[8'h61:8'h66]}) r = {1'b1, 4'(b - 8'h57)};
        return r;
    endfunction

    function automatic result_t make_res(input kind_t k, input logic [7:0] ch,
                                         input logic [8:0] tg,
                                         input logic [FIELD_IDX_W-1:0] fi,
                                         input logic hd, input logic ok);
        result_t r;
        r.kind        = k;
        r.char_value  = ch;
        r.tag_index   = tg[TAG_IDX_W-1:0];
        r.field_index = fi;
        r.hidden      = hd;
        r.all_ok      = ok;
        r.last        = 1'b0;
        return r;
    endfunction

    // effect of the byte as an ordinary (unescaped) byte
    logic                   p_emit;
    kind_t                  p_kind;
    logic [TAG_W-1:0]       p_tag;
    logic [FIELD_IDX_W-1:0] p_arg;
    logic                   p_disc;
    logic                   p_ok;
    esc_t                   p_esc;
    logic [4:0]             hex;
    logic                   e0_v;
    logic                   e1_v;
    result_t                e0;
    result_t                e1;

    assign hex = hex_digit(byte_in);

    always_comb
    begin
        p_emit = 1'b1;
        p_kind = KIND_CHAR;
        p_tag  = tag_cur;
        p_arg  = state_cur.arg;
        p_disc = state_cur.disc;
        p_ok   = state_cur.ok;
        p_esc  = ESC_NORMAL;
        if (byte_in == CH_BSLASH)
        begin
            p_emit = 1'b0;
            p_esc  = ESC_BSL;
        end
        else if (byte_in == CH_SEMI)
        begin
            if (tag_cur == TAG_W'(MAX_TAGS - 1))
                p_ok = 1'b0;
            else
                p_tag = tag_cur + TAG_W'(1);
            p_arg  = '0;
            p_disc = 1'b0;
            p_kind = KIND_TAG;
        end
        else if (byte_in == CH_EQUAL)
        begin
            p_arg  = FIELD_IDX_W'(1);
            p_disc = 1'b0;
            p_kind = KIND_ARG;
        end
        else if (byte_in == CH_COMMA)
        begin
            if (state_cur.arg >= FIELD_IDX_W'(MAX_ARGS))
            begin
                p_disc = 1'b1;
                p_ok   = 1'b0;
                p_kind = KIND_DROPPED;
            end
            else
            begin
                p_arg  = state_cur.arg + FIELD_IDX_W'(1);
                p_kind = KIND_ARG;
            end
        end
    end

    always_comb
    begin
        state_nxt = state_cur;
        tag_nxt   = tag_cur;
        e0_v = 1'b0;
        e1_v = 1'b0;
        e0 = make_res(KIND_CHAR, 8'd0, 9'(tag_cur), state_cur.arg, state_cur.disc,
                      state_cur.ok);
        e1 = make_res(p_kind, (p_kind == KIND_CHAR) ? byte_in : 8'd0, 9'(p_tag),
                      p_arg, p_disc, p_ok);

        if (end_of_string)
        begin
            // open hex escape flushes its value before the end result
            e0_v = (state_cur.esc == ESC_HEX0) || (state_cur.esc == ESC_HEX1);
            e0.char_value = (state_cur.esc == ESC_HEX1) ? {4'd0, state_cur.nib} : 8'd0;
            e1_v = 1'b1;
            e1 = make_res(KIND_END, 8'd0, 9'(tag_cur), state_cur.arg, state_cur.disc,
                          state_cur.ok);
            state_nxt.esc  = ESC_NORMAL;
            state_nxt.nib  = 4'd0;
            state_nxt.arg  = '0;
            state_nxt.disc = 1'b0;
            state_nxt.ok   = 1'b1;
            tag_nxt        = '0;
        end
        else
        begin
            case (state_cur.esc)
                ESC_BSL:
                begin
                    state_nxt.esc = ESC_NORMAL;
                    e0_v = 1'b1;
                    case (byte_in)
                        CH_LOW_B: e0.char_value = CC_BS;
                        CH_LOW_F: e0.char_value = CC_FF;
                        CH_LOW_N: e0.char_value = CC_LF;
                        CH_LOW_R: e0.char_value = CC_CR;
                        CH_LOW_T: e0.char_value = CC_TAB;
                        CH_LOW_X:
                        begin
                            e0_v = 1'b0;
                            state_nxt.esc = ESC_HEX0;
                        end
                        default: e0.char_value = byte_in;
                    endcase
                end
                ESC_HEX0:
                begin
                    if (hex[4])
                    begin
                        state_nxt.nib = hex[3:0];
                        state_nxt.esc = ESC_HEX1;
                    end
                    else
                    begin
                        // cut short: value 0, then the byte as ordinary
                        e0_v = 1'b1;
                        e1_v = p_emit;
                        state_nxt.esc  = p_esc;
                        state_nxt.arg  = p_arg;
                        state_nxt.disc = p_disc;
                        state_nxt.ok   = p_ok;
                        tag_nxt        = p_tag;
                    end
                end
                ESC_HEX1:
                begin
                    e0_v = 1'b1;
                    state_nxt.nib = 4'd0;
                    if (hex[4])
                    begin
                        e0.char_value = {state_cur.nib, hex[3:0]};
                        state_nxt.esc = ESC_NORMAL;
                    end
                    else
                    begin
                        e0.char_value = {4'd0, state_cur.nib};
                        e1_v = p_emit;
                        state_nxt.esc  = p_esc;
                        state_nxt.arg  = p_arg;
                        state_nxt.disc = p_disc;
                        state_nxt.ok   = p_ok;
                        tag_nxt        = p_tag;
                    end
                end
                default:
                begin
                    e1_v = p_emit;
                    state_nxt.esc  = p_esc;
                    state_nxt.arg  = p_arg;
                    state_nxt.disc = p_disc;
                    state_nxt.ok   = p_ok;
                    tag_nxt        = p_tag;
                end
            endcase
        end

        // pack the results in order, the final one carries last
        res_cnt = {1'b0, e0_v} + {1'b0, e1_v};
        res0 = e0_v ? e0 : e1;
        res1 = e1;
        res1.last = 1'b1;
        res0.last = !(e0_v && e1_v);
    end

endmodule
`default_nettype wire

// ===== tb/tagged_string_escape_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_string_escape_parser_checker
// Watches both channels of the parser. It decodes every accepted request with
// its own copy of the parser state, queues the results that request should
// give, and compares each accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module tagged_string_escape_parser_checker
    import tsep_pkg::*;
#(
    parameter int MAX_TAGS = DEF_MAX_TAGS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_stall,
    input  wire logic [7:0]             byte_in,
    input  wire logic                   end_of_string,
    input  wire logic                   out_valid,
    input  wire logic                   out_stall,
    input  wire logic [2:0]             kind,
    input  wire logic [7:0]             char_value,
    input  wire logic [TAG_IDX_W-1:0]   tag_index,
    input  wire logic [FIELD_IDX_W-1:0] field_index,
    input  wire logic                   hidden,
    input  wire logic                   all_ok,
    input  wire logic                   last,
    output int                          mismatches,
    output int                          pending,
    output int                          results_checked,
    output int                          drops_seen,
    output int                          tag_limit_hits
);

    localparam int MAX_PRINTED = 40;

    result_t expected_results[$];

    // parser state as seen from the stream
    esc_t       esc_mode;
    logic [3:0] hi_nibble;
    int         tag_idx;
    int         field_idx;
    logic       discarding;
    logic       ok_flag;

    result_t    step_res[2];
    int         step_n;
    int         err_count;
    int         checked_count;
    int         drop_count;
    int         limit_count;

    function automatic void clear_parse_state();
        esc_mode   = ESC_NORMAL;
        hi_nibble  = 4'h0;
        tag_idx    = 0;
        field_idx  = 0;
        discarding = 1'b0;
        ok_flag    = 1'b1;
    endfunction

    function automatic int hex_digit(logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b) - int'("0");
        if (b >= "A" && b <= "F")
            return int'(b) - int'("A") + 10;
        if (b >= "a" && b <= "f")
            return int'(b) - int'("a") + 10;
        return -1;
    endfunction

    function automatic void add_result(kind_t k, logic [7:0] ch);
        result_t r;
        r.kind        = k;
        r.char_value  = ch;
        r.tag_index   = tag_idx[TAG_IDX_W-1:0];
        r.field_index = field_idx[FIELD_IDX_W-1:0];
        r.hidden      = discarding;
        r.all_ok      = ok_flag;
        r.last        = 1'b0;
        step_res[step_n] = r;
        step_n++;
    endfunction

    function automatic void decode_plain(logic [7:0] b);
        if (b == CH_BSLASH) begin
            esc_mode = ESC_BSL;
        end
        else if (b == CH_SEMI) begin
            // tag index sticks at the last tag once the table is full
            if (tag_idx + 1 >= MAX_TAGS) begin
                ok_flag = 1'b0;
                limit_count++;
            end
            else begin
                tag_idx++;
            end
            field_idx  = 0;
            discarding = 1'b0;
            add_result(KIND_TAG, 8'h00);
        end
        else if (b == CH_EQUAL) begin
            field_idx  = 1;
            discarding = 1'b0;
            add_result(KIND_ARG, 8'h00);
        end
        else if (b == CH_COMMA) begin
            if (field_idx >= MAX_ARGS) begin
                discarding = 1'b1;
                ok_flag    = 1'b0;
                add_result(KIND_DROPPED, 8'h00);
            end
            else begin
                field_idx++;
                add_result(KIND_ARG, 8'h00);
            end
        end
        else begin
            add_result(KIND_CHAR, b);
        end
    endfunction

    function automatic void predict_request(logic [7:0] b, logic eos);
        int h;
        step_n = 0;
        if (eos) begin
            // an open hex escape flushes what it has so far
            if (esc_mode == ESC_HEX0)
                add_result(KIND_CHAR, 8'h00);
            else if (esc_mode == ESC_HEX1)
                add_result(KIND_CHAR, {4'h0, hi_nibble});
            add_result(KIND_END, 8'h00);
            clear_parse_state();
        end
        else begin
            case (esc_mode)
                ESC_BSL:
                begin
                    esc_mode = ESC_NORMAL;
                    case (b)
                        CH_LOW_B: add_result(KIND_CHAR, CC_BS);
                        CH_LOW_F: add_result(KIND_CHAR, CC_FF);
                        CH_LOW_N: add_result(KIND_CHAR, CC_LF);
                        CH_LOW_R: add_result(KIND_CHAR, CC_CR);
                        CH_LOW_T: add_result(KIND_CHAR, CC_TAB);
                        CH_LOW_X: esc_mode = ESC_HEX0;
                        default:  add_result(KIND_CHAR, b);
                    endcase
                end
                ESC_HEX0:
                begin
                    h = hex_digit(b);
                    if (h >= 0) begin
                        hi_nibble = h[3:0];
                        esc_mode  = ESC_HEX1;
                    end
                    else begin
                        esc_mode = ESC_NORMAL;
                        add_result(KIND_CHAR, 8'h00);
                        decode_plain(b);
                    end
                end
                ESC_HEX1:
                begin
                    h = hex_digit(b);
                    esc_mode = ESC_NORMAL;
                    if (h >= 0) begin
                        add_result(KIND_CHAR, {hi_nibble, h[3:0]});
                    end
                    else begin
                        add_result(KIND_CHAR, {4'h0, hi_nibble});
                        decode_plain(b);
                    end
                    hi_nibble = 4'h0;
                end
                default:
                begin
                    decode_plain(b);
                end
            endcase
        end
        if (step_n > 0)
            step_res[step_n-1].last = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_results.push_back(step_res[i]);
    endfunction

    function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v !== exp_v) begin
            err_count++;
            if (err_count <= MAX_PRINTED)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        result_t want;
        if (!rst_n) begin
            clear_parse_state();
            expected_results.delete();
            err_count       = 0;
            checked_count   = 0;
            drop_count      = 0;
            limit_count     = 0;
            mismatches      <= 0;
            pending         <= 0;
            results_checked <= 0;
            drops_seen      <= 0;
            tag_limit_hits  <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                predict_request(byte_in, end_of_string);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_PRINTED)
                        $display("%0t ns: unexpected result, expected none, actual kind %0d",
                                 $time, kind);
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("kind",        8'(want.kind),        8'(kind));
                    check_field("char_value",  want.char_value,      char_value);
                    check_field("tag_index",   8'(want.tag_index),   8'(tag_index));
                    check_field("field_index", 8'(want.field_index), 8'(field_index));
                    check_field("hidden",      8'(want.hidden),      8'(hidden));
                    check_field("all_ok",      8'(want.all_ok),      8'(all_ok));
                    check_field("last",        8'(want.last),        8'(last));
                    checked_count++;
                    if (want.kind == KIND_DROPPED)
                        drop_count++;
                end
            end
            mismatches      <= err_count;
            pending         <= expected_results.size();
            results_checked <= checked_count;
            drops_seen      <= drop_count;
            tag_limit_hits  <= limit_count;
        end
    end

endmodule

// ===== tb/tagged_string_escape_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_string_escape_parser_tb
// Feeds the parser directed escape and delimiter cases, then random display
// strings with bursty requests and a stalling receiver; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tagged_string_escape_parser_tb
    import tsep_pkg::*;
();

    localparam int RANDOM_ITEMS = 1850;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 20000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             byte_in;
    logic                   end_of_string;
    logic                   out_valid;
    logic                   out_stall;
    logic [2:0]             kind;
    logic [7:0]             char_value;
    logic [TAG_IDX_W-1:0]   tag_index;
    logic [FIELD_IDX_W-1:0] field_index;
    logic                   hidden;
    logic                   all_ok;
    logic                   last;

    int mismatches;
    int pending;
    int results_checked;
    int drops_seen;
    int tag_limit_hits;

    int cycle_count = 0;
    int items_sent  = 0;
    int strings_sent = 0;
    int burst_left  = 0;
    int stall_mode  = 0;
    int stall_left  = 0;
    int stall_phase = 0;

    tagged_string_escape_parser i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .byte_in       (byte_in),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .char_value    (char_value),
        .tag_index     (tag_index),
        .field_index   (field_index),
        .hidden        (hidden),
        .all_ok        (all_ok),
        .last          (last)
    );

    tagged_string_escape_parser_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .byte_in         (byte_in),
        .end_of_string   (end_of_string),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .char_value      (char_value),
        .tag_index       (tag_index),
        .field_index     (field_index),
        .hidden          (hidden),
        .all_ok          (all_ok),
        .last            (last),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .drops_seen      (drops_seen),
        .tag_limit_hits  (tag_limit_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILURE");
        $finish;
    end

    // receiver stall pattern, switching between four modes at random
    always @(posedge clk)
    begin
        if (rst_n) begin
            stall_phase <= stall_phase + 1;
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(20, 300);
            end
            else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 9) < 7);
                default: out_stall <= stall_phase[2];
            endcase
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_request(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        in_valid      <= 1'b1;
        byte_in       <= b;
        end_of_string <= eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_request(s[i], 1'b0);
    endtask

    task automatic end_string();
        send_request(8'($urandom_range(0, 255)), 1'b1);
        strings_sent++;
    endtask

    function automatic logic [7:0] rand_hex_char();
        int sel;
        sel = $urandom_range(0, 2);
        if (sel == 0)
            return 8'("0") + 8'($urandom_range(0, 9));
        else if (sel == 1)
            return 8'("A") + 8'($urandom_range(0, 5));
        return 8'("a") + 8'($urandom_range(0, 5));
    endfunction

    task automatic send_escape();
        int sel;
        send_request(CH_BSLASH, 1'b0);
        sel = $urandom_range(0, 9);
        case (sel)
            0: send_request(CH_LOW_B, 1'b0);
            1: send_request(CH_LOW_F, 1'b0);
            2: send_request(CH_LOW_N, 1'b0);
            3: send_request(CH_LOW_R, 1'b0);
            4: send_request(CH_LOW_T, 1'b0);
            5, 6, 7:
            begin
                send_request(CH_LOW_X, 1'b0);
                repeat ($urandom_range(0, 2))
                    send_request(rand_hex_char(), 1'b0);
            end
            default: send_request(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    task automatic send_field_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_request(8'($urandom_range(32, 126)), 1'b0);
        else if (r < 48)
            send_request(CH_SEMI, 1'b0);
        else if (r < 58)
            send_request(CH_EQUAL, 1'b0);
        else if (r < 70)
            send_request(CH_COMMA, 1'b0);
        else if (r < 88)
            send_escape();
        else
            send_request(8'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic send_random_string();
        int style;
        style = $urandom_range(0, 9);
        case (style)
            6:
            begin
                // tag flood, which can run into the tag limit
                repeat ($urandom_range(64, 80)) begin
                    if ($urandom_range(0, 9) != 0)
                        send_request(CH_SEMI, 1'b0);
                    else
                        send_field_item();
                end
            end
            7:
            begin
                // argument flood, which can run past the argument limit
                send_text("t=");
                repeat ($urandom_range(15, 19)) begin
                    send_request(CH_COMMA, 1'b0);
                    repeat ($urandom_range(0, 2))
                        send_request(8'($urandom_range(32, 126)), 1'b0);
                end
                repeat ($urandom_range(0, 6))
                    send_field_item();
            end
            8:
            begin
                repeat ($urandom_range(1, 20))
                    send_request(8'($urandom_range(0, 255)), 1'b0);
            end
            9:
            begin
                if ($urandom_range(0, 1) == 1)
                    send_request(CH_BSLASH, 1'b0);
                if ($urandom_range(0, 1) == 1) begin
                    send_request(CH_LOW_X, 1'b0);
                    repeat ($urandom_range(0, 1))
                        send_request(rand_hex_char(), 1'b0);
                end
            end
            default:
            begin
                repeat ($urandom_range(1, 30))
                    send_field_item();
            end
        endcase
        end_string();
    endtask

    initial
    begin
        int directed_count;
        int drain;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        byte_in       = 8'h00;
        end_of_string = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full hex, hex cut short with and without a digit, control code,
        // comma in a tag name, an equals sign, escaped backslash
        send_text("\\x41\\xg\\xF;\\n,=\\\\");
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        // open hex escape at the end, then a stray backslash at the end
        send_text("\\x");
        end_string();
        send_text("\\");
        end_string();
        directed_count = items_sent;

        while (items_sent < directed_count + RANDOM_ITEMS)
            send_random_string();

        in_valid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while ((pending != 0) && (drain < DRAIN_LIMIT)) begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);

        $display("sent %0d requests in %0d strings, checked %0d results",
                 items_sent, strings_sent, results_checked);
        $display("saw %0d dropped arguments and %0d tag limit hits",
                 drops_seen, tag_limit_hits);
        if (mismatches == 0 && pending == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("%0d mismatches, %0d results still missing", mismatches, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/tsep_pkg.sv
hdl/tsep_step.sv
hdl/tagged_string_escape_parser.sv
tb/tagged_string_escape_parser_checker.sv
tb/tagged_string_escape_parser_tb.sv
